// File: rtl/sccd_pkg.sv
package sccd_pkg;

  localparam logic [7:0]  SyncFirst  = 8'hDE;
  localparam logic [7:0]  SyncSecond = 8'hC0;
  localparam logic [3:0]  PhaseHunt  = 4'd0;
  localparam logic [3:0]  PhaseChkHi = 4'd1;
  localparam logic [3:0]  PhaseChkLo = 4'd2;
  localparam logic [3:0]  PhaseFirst = 4'd5;
  localparam logic [3:0]  PhaseSecnd = 4'd8;
  localparam logic [3:0]  PhaseThird = 4'd11;
  localparam logic [3:0]  LastPhase  = 4'd13;
  localparam logic [23:0] KeptReset  = 24'd100;

  // one result item
  typedef struct packed {
    logic signed [23:0] first_value;
    logic signed [23:0] second_value;
    logic signed [23:0] third_value;
    logic               frame_ok;
    logic [31:0]        good_count;
  } result_t;

endpackage

// File: rtl/sccd_deframer.sv
module sccd_deframer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output logic            last_byte,
  output sccd_pkg::result_t res
);
  import sccd_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic        saw_r, saw_nxt;
  logic [15:0] check_r, check_nxt;
  logic [11:0] sum_r, sum_nxt;
  logic [23:0] col1_r, col1_nxt, col2_r, col2_nxt, col3_r, col3_nxt;
  logic [23:0] kept1_r, kept1_nxt, kept2_r, kept2_nxt, kept3_r, kept3_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        ok;

  assign last_byte = (phase_r == LastPhase);
  assign ok = ({4'd0, sum_nxt} == ~check_r);

  // per-byte frame state update
  always_comb begin
    phase_nxt = phase_r;
    saw_nxt   = saw_r;
    check_nxt = check_r;
    sum_nxt   = sum_r;
    col1_nxt  = col1_r;
    col2_nxt  = col2_r;
    col3_nxt  = col3_r;
    kept1_nxt = kept1_r;
    kept2_nxt = kept2_r;
    kept3_nxt = kept3_r;
    cnt_nxt   = cnt_r;
    if (phase_r == PhaseHunt || phase_r > LastPhase) begin
      if (saw_r && rx_byte == SyncSecond) begin
        phase_nxt = PhaseChkHi;
        saw_nxt   = 1'b0;
      end else begin
        phase_nxt = PhaseHunt;
        saw_nxt   = (rx_byte == SyncFirst);
      end
    end else if (phase_r <= PhaseChkLo) begin
      check_nxt = {check_r[7:0], rx_byte};
      sum_nxt   = '0;
      phase_nxt = phase_r + 4'd1;
    end else begin
      sum_nxt = sum_r + {4'd0, rx_byte};
      if (phase_r >= PhaseThird) begin
        col3_nxt = {col3_r[15:0], rx_byte};
      end else if (phase_r >= PhaseSecnd) begin
        col2_nxt = {col2_r[15:0], rx_byte};
      end else if (phase_r >= PhaseFirst) begin
        col1_nxt = {col1_r[15:0], rx_byte};
      end
      if (phase_r < LastPhase) begin
        phase_nxt = phase_r + 4'd1;
      end else begin
        phase_nxt = PhaseHunt;
        saw_nxt   = 1'b0;
        if (ok) begin
          kept1_nxt = col1_nxt;
          kept2_nxt = col2_nxt;
          kept3_nxt = col3_nxt;
          cnt_nxt   = cnt_r + 32'd1;
        end
      end
    end
  end

  // result of the last payload byte
  always_comb begin
    res.first_value  = kept1_nxt;
    res.second_value = kept2_nxt;
    res.third_value  = kept3_nxt;
    res.frame_ok     = ok;
    res.good_count   = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhaseHunt;
      saw_r   <= 1'b0;
      check_r <= '0;
      sum_r   <= '0;
      col1_r  <= '0;
      col2_r  <= '0;
      col3_r  <= '0;
      kept1_r <= KeptReset;
      kept2_r <= KeptReset;
      kept3_r <= KeptReset;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      saw_r   <= saw_nxt;
      check_r <= check_nxt;
      sum_r   <= sum_nxt;
      col1_r  <= col1_nxt;
      col2_r  <= col2_nxt;
      col3_r  <= col3_nxt;
      kept1_r <= kept1_nxt;
      kept2_r <= kept2_nxt;
      kept3_r <= kept3_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/sync_checksum_frame_deframer_core.sv
// Output: the result of a frame is registered from the held last payload byte.
// Throughput: one byte per cycle; a held byte moves on every cycle unless it ends
// a frame while the previous result is still held and stalled.
// Reset: synchronous, active low; clears the frame state, the good-frame count
// and both valid flags; kept values return to 100.
module sync_checksum_frame_deframer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_first_value,
  output logic signed [23:0] out_second_value,
  output logic signed [23:0] out_third_value,
  output logic               out_frame_ok,
  output logic [31:0]        out_good_count
);
  import sccd_pkg::*;

  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       out_v_r, out_v_nxt;
  result_t    out_r;
  result_t    res;
  logic       last_byte;
  logic       out_free;
  logic       advance;
  logic       load;
  logic       in_take;

  // byte moves on unless it would finish a frame into a full, stalled output slot
  assign out_free = !out_v_r || !out_stall;
  assign advance  = in_v_r && (!last_byte || out_free);
  assign load     = advance && last_byte;
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  sccd_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .last_byte (last_byte),
    .res       (res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_first_value  = out_r.first_value;
  assign out_second_value = out_r.second_value;
  assign out_third_value  = out_r.third_value;
  assign out_frame_ok     = out_r.frame_ok;
  assign out_good_count   = out_r.good_count;

  // a result never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_v_r) |-> !out_stall)
    else $error("result register overwritten while stalled");

  // only a held byte can stall the input
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with empty register");

  // a held byte that is not a frame end never waits
  a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !last_byte) |-> advance)
    else $error("non-final byte held back");

endmodule
